// ===== rtl/fjv_pkg.sv =====
package fjv_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = 40;
	localparam int VAL_W      = 32;
	localparam int GAIN_W     = 23;
	localparam int LIM_W      = 31;
	localparam int AXIS_W     = 31;
	localparam int ROOT_SHIFT = 10;
	localparam int ADDR_W     = 5;

	localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;

	localparam logic [GAIN_W-1:0]        GAIN_KP_RST   = 23'd19661;
	localparam logic signed [VAL_W-1:0]  ACCEL_MIN_RST = -32'sd196608;
	localparam logic [LIM_W-1:0]         ACCEL_MAX_RST = 31'd131072;
	localparam logic signed [VAL_W-1:0]  JERK_MIN_RST  = -32'sd32768;
	localparam logic [LIM_W-1:0]         JERK_MAX_RST  = 31'd65536;

	typedef enum logic [2:0] {
		REG_GAIN_KP,
		REG_ACCEL_MIN,
		REG_ACCEL_MAX,
		REG_JERK_MIN,
		REG_JERK_MAX
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]       gain_kp;
		logic signed [VAL_W-1:0] accel_min;
		logic [LIM_W-1:0]        accel_max;
		logic signed [VAL_W-1:0] jerk_min;
		logic [LIM_W-1:0]        jerk_max;
	} cfg_t;

	typedef struct packed {
		logic                    is_start;
		logic                    scaled;
		logic [AXIS_W-1:0]       ax;
		logic [AXIS_W-1:0]       ay;
		logic signed [VAL_W-1:0] ref_vel;
		logic signed [VAL_W-1:0] init_vel;
		logic signed [VAL_W-1:0] init_acc;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_ROOT,
		ST_DT_WAIT,
		ST_VEL,
		ST_CMD,
		ST_JERK,
		ST_JERK_WAIT,
		ST_ACC,
		ST_DONE
	} back_st_t;

	function automatic logic ovf32(input logic signed [65:0] v);
		return (v > 66'sd2147483647) || (v < -66'sd2147483648);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [65:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	// hi first, then lo, so a crossed pair resolves to lo
	function automatic logic signed [VAL_W-1:0] clamp32(input logic signed [63:0] v,
			input logic signed [VAL_W-1:0] lo, input logic [LIM_W-1:0] hi);
		logic signed [63:0] r;
		r = v;
		if (r > 64'($signed({1'b0, hi}))) r = 64'($signed({1'b0, hi}));
		if (r < 64'(lo)) r = 64'(lo);
		return r[VAL_W-1:0];
	endfunction

endpackage

// ===== rtl/fjv_if.sv =====
interface fjv_point_if import fjv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    is_start;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [VAL_W-1:0] ref_vel;
	logic signed [VAL_W-1:0] init_vel;
	logic signed [VAL_W-1:0] init_acc;

	modport source (output valid, is_start, pos_x, pos_y, ref_vel, init_vel, init_acc,
		input ready);
	modport sink (input valid, is_start, pos_x, pos_y, ref_vel, init_vel, init_acc,
		output ready);
endinterface

interface fjv_result_if import fjv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_vel;
	logic signed [VAL_W-1:0] out_acc;
	logic                    saturated;

	modport source (output valid, out_vel, out_acc, saturated, input ready);
	modport sink (input valid, out_vel, out_acc, saturated, output ready);
endinterface

// ===== rtl/fjv_front.sv =====
module fjv_front import fjv_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fjv_point_if.sink     points,
	input  fifo_stat_t    fq_stat,
	output logic          push,
	output job_t          job
);

	logic signed [POS_W-1:0] last_x_q, last_y_q;
	logic signed [POS_W:0]   dx, dy;
	logic [POS_W-1:0]        adx, ady;
	logic                    scaled;

	assign points.ready = !fq_stat.full;
	assign push = points.valid && points.ready;

	always_comb begin
		dx = (POS_W+1)'(points.pos_x) - (POS_W+1)'(last_x_q);
		dy = (POS_W+1)'(points.pos_y) - (POS_W+1)'(last_y_q);
		adx = dx[POS_W] ? POS_W'(-dx) : POS_W'(dx);
		ady = dy[POS_W] ? POS_W'(-dy) : POS_W'(dy);
		// long steps lose ten bits so the squares stay inside 63 bits
		scaled = (adx[POS_W-1:AXIS_W] != '0) || (ady[POS_W-1:AXIS_W] != '0);
		job.is_start = points.is_start;
		job.scaled   = scaled;
		job.ax       = scaled ? AXIS_W'(adx >> ROOT_SHIFT) : adx[AXIS_W-1:0];
		job.ay       = scaled ? AXIS_W'(ady >> ROOT_SHIFT) : ady[AXIS_W-1:0];
		job.ref_vel  = points.ref_vel;
		job.init_vel = points.init_vel;
		job.init_acc = points.init_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (push) begin
			last_x_q <= points.pos_x;
			last_y_q <= points.pos_y;
		end
	end

endmodule

// ===== rtl/fjv_fifo.sv =====
module fjv_fifo import fjv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       wr_job,
	input  logic       pop,
	output job_t       rd_job,
	output fifo_stat_t stat
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/fjv_div.sv =====
module fjv_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [63:0] quo
);

	logic [31:0] rem_q, den_q;
	logic [63:0] quo_q;
	logic [5:0]  cnt_q;
	logic        run_q, done_q;
	logic [32:0] trial;
	logic        take;

	assign done = done_q;
	assign quo  = quo_q;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, quo_q[63]};
		take  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= take ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[62:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == 6'd63);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) run_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fjv_back.sv =====
module fjv_back import fjv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  fifo_stat_t  fq_stat,
	input  job_t        head,
	output logic        pop,
	fjv_result_if.source results
);

	back_st_t st_q, st_d;
	job_t     job_q;

	logic [63:0] n_q, res_q, rbit_q;
	logic signed [VAL_W-1:0] last_vel_q, last_acc_q, vel_q, acc_q, cmd_q, jerk_q;
	logic [LIM_W-1:0] dt_q;
	logic             sat_q, neg_q;

	logic                    out_valid_q, out_sat_q;
	logic signed [VAL_W-1:0] out_vel_q, out_acc_q;
	logic                    out_free;

	logic        div_start, div_done;
	logic [63:0] div_num, div_quo;
	logic [31:0] div_den;

	logic [63:0] ds, root_sum;
	logic [61:0] sq_x, sq_y;
	logic        ds_big, root_take, dt_zero, dt_big;
	logic [31:0] vf;
	logic signed [63:0] prod_va, prod_ja, jnum, jerk_w;
	logic signed [56:0] prod_cmd;
	logic signed [32:0] vdiff, jdiff;
	logic signed [65:0] vel_w, acc_w;

	assign out_free          = !out_valid_q || results.ready;
	assign results.valid     = out_valid_q;
	assign results.out_vel   = out_vel_q;
	assign results.out_acc   = out_acc_q;
	assign results.saturated = out_sat_q;

	fjv_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		sq_x      = job_q.ax * job_q.ax;
		sq_y      = job_q.ay * job_q.ay;
		root_sum  = res_q + rbit_q;
		root_take = n_q >= root_sum;
		ds        = job_q.scaled ? (res_q << ROOT_SHIFT) : res_q;
		ds_big    = (ds >> (63 - FRAC_BITS)) != '0;
		vf        = (last_vel_q > ONE_Q) ? 32'(last_vel_q) : 32'(ONE_Q);
		dt_big    = div_quo[63:LIM_W] != '0;
		dt_zero   = div_quo == '0;
		prod_va   = last_acc_q * $signed({1'b0, dt_q});
		vel_w     = 66'(last_vel_q) + 66'(prod_va >>> FRAC_BITS);
		vdiff     = 33'(job_q.ref_vel) - 33'(vel_q);
		prod_cmd  = $signed({1'b0, cfg.gain_kp}) * vdiff;
		jdiff     = 33'(cmd_q) - 33'(last_acc_q);
		jnum      = 64'(jdiff) <<< FRAC_BITS;
		jerk_w    = neg_q ? -$signed(div_quo) : $signed(div_quo);
		prod_ja   = jerk_q * $signed({1'b0, dt_q});
		acc_w     = 66'(last_acc_q) + 66'(prod_ja >>> FRAC_BITS);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:      if (!fq_stat.empty) st_d = head.is_start ? ST_DONE : ST_SQX;
			ST_SQX:       st_d = ST_SQY;
			ST_SQY:       st_d = ST_ROOT;
			ST_ROOT:      if (rbit_q == '0) st_d = ds_big ? ST_VEL : ST_DT_WAIT;
			ST_DT_WAIT:   if (div_done) st_d = (!dt_big && dt_zero) ? ST_DONE : ST_VEL;
			ST_VEL:       st_d = ST_CMD;
			ST_CMD:       st_d = ST_JERK;
			ST_JERK:      st_d = ST_JERK_WAIT;
			ST_JERK_WAIT: if (div_done) st_d = ST_ACC;
			ST_ACC:       st_d = ST_DONE;
			ST_DONE:      if (out_free) st_d = ST_IDLE;
			default:      st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		div_num   = ds << FRAC_BITS;
		div_den   = vf;
		unique case (st_q)
			ST_IDLE: pop = !fq_stat.empty;
			ST_ROOT: div_start = (rbit_q == '0) && !ds_big;
			ST_JERK: begin
				div_start = 1'b1;
				div_num   = jnum[63] ? 64'(-jnum) : 64'(jnum);
				div_den   = {1'b0, dt_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q <= head;
				vel_q <= head.init_vel;
				acc_q <= head.init_acc;
				sat_q <= 1'b0;
			end
			ST_SQX: n_q <= 64'(sq_x);
			ST_SQY: begin
				n_q    <= n_q + 64'(sq_y);
				res_q  <= '0;
				rbit_q <= 64'(1) << 62;
			end
			ST_ROOT: begin
				if (rbit_q != '0) begin
					if (root_take) begin
						n_q   <= n_q - root_sum;
						res_q <= (res_q >> 1) + rbit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					rbit_q <= rbit_q >> 2;
				end else if (ds_big) begin
					dt_q  <= '1;
					sat_q <= 1'b1;
				end
			end
			ST_DT_WAIT: begin
				if (div_done) begin
					dt_q  <= dt_big ? '1 : div_quo[LIM_W-1:0];
					sat_q <= sat_q | dt_big;
					vel_q <= last_vel_q;
					acc_q <= last_acc_q;
				end
			end
			ST_VEL: begin
				vel_q <= sat32(vel_w);
				sat_q <= sat_q | ovf32(vel_w);
			end
			ST_CMD: cmd_q <= clamp32(64'(prod_cmd >>> FRAC_BITS), cfg.accel_min, cfg.accel_max);
			ST_JERK: neg_q <= jnum[63];
			ST_JERK_WAIT: begin
				if (div_done) jerk_q <= clamp32(jerk_w, cfg.jerk_min, cfg.jerk_max);
			end
			ST_ACC: begin
				acc_q <= sat32(acc_w);
				sat_q <= sat_q | ovf32(acc_w);
			end
			ST_DONE: begin
				if (out_free) begin
					out_vel_q <= vel_q;
					out_acc_q <= acc_q;
					out_sat_q <= sat_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
			last_vel_q  <= '0;
			last_acc_q  <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				last_vel_q  <= vel_q;
				last_acc_q  <= acc_q;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/forward_jerk_limited_velocity_filter.sv =====
// Forward jerk-limited velocity filter. Each point item gives one result item. A start
// item goes straight to the result; any other point is squared per axis, passes a
// bit-pair square root, then up to two 64-step serial divisions (dt, then jerk) on the
// one shared divider, with multiplies between. A two-entry queue lets the input side
// take up to two further points while one is being worked on, and the result register
// holds a finished item until it is taken.
module forward_jerk_limited_velocity_filter import fjv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fjv_point_if.sink         points,
	fjv_result_if.source      results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg_q;
	fifo_stat_t fq_stat;
	job_t       push_job, head_job;
	logic       push, pop;
	reg_idx_t   idx;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_kp   <= GAIN_KP_RST;
			cfg_q.accel_min <= ACCEL_MIN_RST;
			cfg_q.accel_max <= ACCEL_MAX_RST;
			cfg_q.jerk_min  <= JERK_MIN_RST;
			cfg_q.jerk_max  <= JERK_MAX_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_GAIN_KP:   cfg_q.gain_kp   <= pwdata[GAIN_W-1:0];
				REG_ACCEL_MIN: cfg_q.accel_min <= pwdata;
				REG_ACCEL_MAX: cfg_q.accel_max <= pwdata[LIM_W-1:0];
				REG_JERK_MIN:  cfg_q.jerk_min  <= pwdata;
				REG_JERK_MAX:  cfg_q.jerk_max  <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GAIN_KP:   prdata = 32'(cfg_q.gain_kp);
			REG_ACCEL_MIN: prdata = cfg_q.accel_min;
			REG_ACCEL_MAX: prdata = 32'(cfg_q.accel_max);
			REG_JERK_MIN:  prdata = cfg_q.jerk_min;
			REG_JERK_MAX:  prdata = 32'(cfg_q.jerk_max);
			default:       prdata = '0;
		endcase
	end

	fjv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.points (points),
		.fq_stat(fq_stat),
		.push   (push),
		.job    (push_job)
	);

	fjv_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(push_job),
		.pop   (pop),
		.rd_job(head_job),
		.stat  (fq_stat)
	);

	fjv_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.fq_stat(fq_stat),
		.head   (head_job),
		.pop    (pop),
		.results(results)
	);

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fq_stat.full && fq_stat.empty))
		else $error("queue reports full and empty together");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.ready) |=> !fq_stat.empty)
		else $error("accepted item missing from queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fq_stat.empty)
		else $error("queue popped while empty");

endmodule
